@@ hw/rtl/upc_pkg.sv @@
package upc_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;

	typedef struct packed {
		logic [1:0]      count;
		logic [2:0][7:0] bytes;
		logic            last;
		logic            trunc;
	} res_set_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_alnum(input logic [7:0] b);
		return is_digit(b) || ((b >= 8'h41) && (b <= 8'h5A)) ||
			((b >= 8'h61) && (b <= 8'h7A));
	endfunction

	function automatic logic [7:0] nibble_char(input logic [3:0] v);
		logic [7:0] w;
		w = {4'd0, v};
		return (v > 4'd9) ? (w - 8'd10 + CH_UPPER_A) : (w + CH_ZERO);
	endfunction

	function automatic logic [7:0] digit_value(input logic [7:0] b);
		return is_digit(b) ? (b - CH_ZERO) : (b - CH_UPPER_A + 8'd10);
	endfunction

endpackage

@@ hw/rtl/upc_conv.sv @@
module upc_conv
	import upc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic [7:0] byte_s1,
	input  logic       eos_s1,
	input  logic       advance,
	output res_set_t   res
);

	logic       direction_q;
	logic [1:0] phase_q;
	logic [7:0] high_q;
	logic [1:0] phase_d;
	logic [7:0] high_d;
	logic [7:0] dv;
	logic [7:0] hp;

	always_comb begin
		res     = '0;
		phase_d = PH_IDLE;
		high_d  = high_q;
		dv      = digit_value(byte_s1);
		hp      = {dv[3:0], 4'd0};
		if (direction_q == DIR_ENCODE) begin
			if (is_alnum(byte_s1)) begin
				res.count    = 2'd1;
				res.bytes[0] = byte_s1;
			end else begin
				res.count    = 2'd3;
				res.bytes[0] = CH_PERCENT;
				res.bytes[1] = nibble_char(byte_s1[7:4]);
				res.bytes[2] = nibble_char(byte_s1[3:0]);
			end
			res.last = eos_s1;
		end else begin
			unique case (phase_q)
				PH_HIGH: begin
					if (eos_s1) begin
						res.count    = 2'd1;
						res.bytes[0] = hp;
						res.last     = 1'b1;
						res.trunc    = 1'b1;
						high_d       = 8'd0;
					end else begin
						phase_d = PH_LOW;
						high_d  = hp;
					end
				end
				PH_LOW: begin
					res.count    = 2'd1;
					res.bytes[0] = high_q | dv;
					res.last     = eos_s1;
					high_d       = 8'd0;
				end
				default: begin
					if (byte_s1 == CH_PERCENT) begin
						if (eos_s1) begin
							res.count = 2'd1;
							res.last  = 1'b1;
							res.trunc = 1'b1;
							high_d    = 8'd0;
						end else begin
							phase_d = PH_HIGH;
						end
					end else begin
						res.count    = 2'd1;
						res.bytes[0] = (byte_s1 == CH_PLUS) ? CH_SPACE : byte_s1;
						res.last     = eos_s1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_ENCODE;
			phase_q     <= PH_IDLE;
			high_q      <= 8'd0;
		end else if (cfg_wr_en) begin
			direction_q <= cfg_wr_data;
			phase_q     <= PH_IDLE;
			high_q      <= 8'd0;
		end else if (advance) begin
			phase_q <= phase_d;
			high_q  <= high_d;
		end
	end

endmodule

@@ hw/rtl/upc_emit.sv @@
module upc_emit
	import upc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  res_set_t   res,
	input  logic       load,
	output logic       can_load,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_out,
	output logic       truncated
);

	logic            busy_q;
	logic [1:0]      idx_q;
	logic [1:0]      count_q;
	logic [2:0][7:0] bytes_q;
	logic            last_q;
	logic            trunc_q;
	logic            take;
	logic            final_item;

	assign out_valid  = busy_q;
	assign take       = busy_q && out_ready;
	assign final_item = (idx_q == (count_q - 2'd1));
	assign can_load   = !busy_q || (take && final_item);
	assign last_out   = last_q && final_item;
	assign truncated  = trunc_q && final_item;

	always_comb begin
		unique case (idx_q)
			2'd0:    out_byte = bytes_q[0];
			2'd1:    out_byte = bytes_q[1];
			default: out_byte = bytes_q[2];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= 2'd0;
			count_q <= 2'd1;
		end else if (load && (res.count != 2'd0)) begin
			busy_q  <= 1'b1;
			idx_q   <= 2'd0;
			count_q <= res.count;
		end else if (take) begin
			if (final_item) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && (res.count != 2'd0)) begin
			bytes_q <= res.bytes;
			last_q  <= res.last;
			trunc_q <= res.trunc;
		end
	end

endmodule

@@ hw/rtl/url_percent_codec_top.sv @@
// Path: a result is held in the input register (byte_s1), then loaded into the output register
// of upc_emit, which offers it on out_valid; a busy output register stalls that load.
// Throughput: one input byte per cycle while out_ready is high, except an encoded escape,
// which holds the input until the output register has sent all three of its bytes, one per cycle.
// Reset: arst_n clears the handshake state, the direction (encode) and the escape state.
module url_percent_codec_top
	import upc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_out,
	output logic       truncated
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;
	logic       can_load;
	logic       advance;
	res_set_t   res;

	assign advance  = valid_s1 && can_load;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			eos_s1  <= end_of_string;
		end
	end

	upc_conv u_conv (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.byte_s1     (byte_s1),
		.eos_s1      (eos_s1),
		.advance     (advance),
		.res         (res)
	);

	upc_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.load      (advance),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last_out  (last_out),
		.truncated (truncated)
	);

endmodule
